/* rtl/iir_direct_form_one_filter_macros.svh */
// assertion macros used by the filter module
`ifndef IIR_DIRECT_FORM_ONE_FILTER_MACROS_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_MACROS_SVH

// clocked property, disabled while reset is asserted
`define IIR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define IIR_ASSERT_IMPL(label, ante, cons, msg) \
  `IIR_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication
`define IIR_ASSERT_NEXT(label, ante, cons, msg) \
  `IIR_ASSERT(label, (ante) |=> (cons), msg)

`endif

/* rtl/iirdf1_pkg.sv */
// shared widths, constants and types of the direct form I filter
package iirdf1_pkg;

  localparam int unsigned COEF_W     = 18;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned PROD_W     = COEF_W + SAMPLE_W;
  localparam int unsigned ACC_W      = PROD_W + 4;
  localparam int unsigned FRAC_SHIFT = 14;
  localparam int unsigned RND_W      = ACC_W - FRAC_SHIFT;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned STEP_W     = 3;
  localparam int unsigned FILL_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FWD0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FWD1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FWD2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FBK1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FBK2 = 3'd4;

  localparam logic signed [COEF_W-1:0] COEF_ONE  = 18'sd16384;
  localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;
  localparam logic [ACC_W-1:0]         ROUND_HALF = ACC_W'(1) << (FRAC_SHIFT - 1);

  // command to the shared multiply-accumulate unit
  typedef struct packed {
    logic valid;
    logic first;
    logic sub;
  } mac_ctl_t;

endpackage

/* rtl/iirdf1_mac.sv */
// shared multiply-accumulate unit: registered product, then accumulate
module iirdf1_mac (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  iirdf1_pkg::mac_ctl_t                   ctl_i,
  input  logic signed [iirdf1_pkg::COEF_W-1:0]   coef_i,
  input  logic signed [iirdf1_pkg::SAMPLE_W-1:0] data_i,
  output logic signed [iirdf1_pkg::ACC_W-1:0]    acc_o
);
  import iirdf1_pkg::*;

  logic signed [PROD_W-1:0] prod_d, prod_q;
  mac_ctl_t                 pctl_q;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc_d, acc_q;

  assign prod_d = coef_i * data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pctl_q <= '0;
    end else begin
      pctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    term  = pctl_q.sub ? -ACC_W'(prod_q) : ACC_W'(prod_q);
    acc_d = acc_q;
    if (pctl_q.valid) begin
      acc_d = (pctl_q.first ? '0 : acc_q) + term;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

/* rtl/iir_direct_form_one_filter.sv */
// direct form I iir filter: one shared mac stepped over 2*K+1 products per sample
// K = kept taps (min of samples since restart and FILTER_ORDER)
// one sample at a time: a new sample is taken only when idle, after the last result is registered for output
// reset: b0 = 1.0, other coefficients zero, fill count zero, no output pending
module iir_direct_form_one_filter #(
  parameter int unsigned FILTER_ORDER = 2
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [iirdf1_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [iirdf1_pkg::COEF_W-1:0]           cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [iirdf1_pkg::SAMPLE_W-1:0]  sample_in_i,
  input  logic                                    restart_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [iirdf1_pkg::SAMPLE_W-1:0]  filtered_out_o,
  output logic                                    clipped_o
);
  import iirdf1_pkg::*;
`include "iir_direct_form_one_filter_macros.svh"

  localparam int unsigned HIST_IDX_W = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;
  localparam logic [FILL_W-1:0] ORDER_L = FILL_W'(FILTER_ORDER);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state_d, state_q;
  logic [STEP_W-1:0] step_d, step_q;
  logic [STEP_W-1:0] last_step;
  logic [FILL_W-1:0] fill_q, taps_q;

  logic signed [COEF_W-1:0] fwd0_q, fwd1_q, fwd2_q, fbk1_q, fbk2_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [SAMPLE_W-1:0] raw_q  [FILTER_ORDER];
  logic signed [SAMPLE_W-1:0] filt_q [FILTER_ORDER];

  logic in_fire, out_fire, done_fire;
  logic out_valid_q;
  logic signed [SAMPLE_W-1:0] y_q;
  logic clip_q;

  logic [FILL_W-1:0] tap;
  logic [HIST_IDX_W-1:0] hidx;
  mac_ctl_t mac_ctl;
  logic signed [COEF_W-1:0] mac_coef;
  logic signed [SAMPLE_W-1:0] mac_data;
  logic signed [ACC_W-1:0] acc;

  logic [ACC_W-1:0] rnd_sum;
  logic signed [RND_W-1:0] rnd;
  logic signed [SAMPLE_W-1:0] y_d;
  logic clip_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd0_q <= COEF_ONE;
      fwd1_q <= COEF_ZERO;
      fwd2_q <= COEF_ZERO;
      fbk1_q <= COEF_ZERO;
      fbk2_q <= COEF_ZERO;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FWD0: fwd0_q <= cfg_data_i;
        CFG_FWD1: fwd1_q <= cfg_data_i;
        CFG_FWD2: fwd2_q <= cfg_data_i;
        CFG_FBK1: fbk1_q <= cfg_data_i;
        CFG_FBK2: fbk2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;
  assign done_fire  = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign last_step  = {taps_q, 1'b0};

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_RUN;
          step_d  = '0;
        end
      end
      ST_RUN: begin
        if (step_q == last_step) begin
          state_d = ST_DRAIN;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE: begin
        if (done_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      fill_q      <= '0;
      taps_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (in_fire) begin
        taps_q <= restart_i ? '0 : fill_q;
      end
      if (done_fire) begin
        fill_q <= (taps_q < ORDER_L) ? taps_q + FILL_W'(1) : taps_q;
      end
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // histories are gated by the tap count, so a restart only drops the fill count
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q <= sample_in_i;
    end
    if (done_fire) begin
      y_q    <= y_d;
      clip_q <= clip_d;
      for (int j = FILTER_ORDER - 1; j > 0; j--) begin
        raw_q[j]  <= raw_q[j-1];
        filt_q[j] <= filt_q[j-1];
      end
      raw_q[0]  <= x_q;
      filt_q[0] <= y_d;
    end
  end

  // step 0 is b0*x, odd steps feedforward taps, even steps feedback taps
  assign tap  = step_q[STEP_W-1:1] + FILL_W'(step_q[0]);
  assign hidx = (tap != '0) ? HIST_IDX_W'(tap - FILL_W'(1)) : '0;

  always_comb begin
    mac_ctl.valid = (state_q == ST_RUN);
    mac_ctl.first = (step_q == '0);
    mac_ctl.sub   = (step_q != '0) && !step_q[0];
    mac_coef      = COEF_ZERO;
    mac_data      = x_q;
    if (step_q == '0) begin
      mac_coef = fwd0_q;
    end else if (step_q[0]) begin
      mac_data = raw_q[hidx];
      case (tap)
        FILL_W'(1): mac_coef = fwd1_q;
        FILL_W'(2): mac_coef = fwd2_q;
        default:    mac_coef = COEF_ZERO;
      endcase
    end else begin
      mac_data = filt_q[hidx];
      case (tap)
        FILL_W'(1): mac_coef = fbk1_q;
        FILL_W'(2): mac_coef = fbk2_q;
        default:    mac_coef = COEF_ZERO;
      endcase
    end
  end

  iirdf1_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .coef_i (mac_coef),
    .data_i (mac_data),
    .acc_o  (acc)
  );

  // round half up, then saturate to q1.15
  always_comb begin
    rnd_sum = acc + ROUND_HALF;
    rnd     = rnd_sum[ACC_W-1:FRAC_SHIFT];
    if (rnd[RND_W-1:SAMPLE_W-1] == '0 || rnd[RND_W-1:SAMPLE_W-1] == '1) begin
      y_d    = rnd[SAMPLE_W-1:0];
      clip_d = 1'b0;
    end else begin
      y_d    = rnd[RND_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
      clip_d = 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign filtered_out_o = y_q;
  assign clipped_o      = clip_q;

  `IIR_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready_o, "ready after accepted transaction")
  `IIR_ASSERT(a_fill_bound, fill_q <= ORDER_L, "fill count above filter order")
  `IIR_ASSERT_IMPL(a_step_bound, state_q == ST_RUN, step_q <= last_step, "step past last product")
  `IIR_ASSERT_IMPL(a_out_from_done, $rose(out_valid_q), $past(state_q == ST_DONE), "output without done")

endmodule

/* tb/iirdf1_checker.sv */
// transaction monitor, filter predictor and result scoreboard for the direct form I filter
`timescale 1ns / 1ps
module iirdf1_checker #(
  parameter int unsigned FILTER_ORDER = 2
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  input  logic                                    cfg_ready_i,
  input  logic [iirdf1_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [iirdf1_pkg::COEF_W-1:0]           cfg_data_i,
  input  logic                                    in_valid_i,
  input  logic                                    in_ready_i,
  input  logic signed [iirdf1_pkg::SAMPLE_W-1:0]  sample_in_i,
  input  logic                                    restart_i,
  input  logic                                    out_valid_i,
  input  logic                                    out_ready_i,
  input  logic signed [iirdf1_pkg::SAMPLE_W-1:0]  filtered_out_i,
  input  logic                                    clipped_i,
  output int                                      fail_count_o,
  output int                                      pending_o,
  output int                                      results_o,
  output int                                      clip_count_o
);

  localparam int MAX_TAPS   = 4;
  localparam longint OUT_MAX = (longint'(1) <<< (iirdf1_pkg::SAMPLE_W - 1)) - 1;
  localparam longint OUT_MIN = -(longint'(1) <<< (iirdf1_pkg::SAMPLE_W - 1));

  typedef struct {
    logic signed [iirdf1_pkg::SAMPLE_W-1:0] filtered;
    logic                                   clipped;
  } filter_result_t;

  logic signed [iirdf1_pkg::COEF_W-1:0]   fwd_coef  [MAX_TAPS];
  logic signed [iirdf1_pkg::COEF_W-1:0]   fbk_coef  [MAX_TAPS];
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] raw_hist  [FILTER_ORDER];
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] filt_hist [FILTER_ORDER];
  int                                     kept;
  int                                     fails;
  int                                     seen;
  int                                     clips;
  filter_result_t                         expected_results [$];

  function automatic filter_result_t filter_sample(
    input logic signed [iirdf1_pkg::SAMPLE_W-1:0] x,
    input logic                                   restart
  );
    filter_result_t r;
    longint         acc;
    longint         y;
    int             taps;
    int             i;
    if (restart) begin
      for (i = 0; i < FILTER_ORDER; i++) begin
        raw_hist[i]  = '0;
        filt_hist[i] = '0;
      end
      kept = 0;
    end
    taps = (kept < FILTER_ORDER) ? kept : FILTER_ORDER;
    acc  = longint'(fwd_coef[0]) * longint'(x);
    for (i = 1; i <= taps && i < MAX_TAPS; i++) begin
      acc += longint'(fwd_coef[i]) * longint'(raw_hist[i-1])
           - longint'(fbk_coef[i]) * longint'(filt_hist[i-1]);
    end
    // round half up, then floor to q1.15
    y = (acc + (longint'(1) <<< (iirdf1_pkg::FRAC_SHIFT - 1))) >>> iirdf1_pkg::FRAC_SHIFT;
    r.clipped = 1'b0;
    if (y > OUT_MAX) begin
      y         = OUT_MAX;
      r.clipped = 1'b1;
    end else if (y < OUT_MIN) begin
      y         = OUT_MIN;
      r.clipped = 1'b1;
    end
    r.filtered = y[iirdf1_pkg::SAMPLE_W-1:0];
    for (i = FILTER_ORDER - 1; i > 0; i--) begin
      raw_hist[i]  = raw_hist[i-1];
      filt_hist[i] = filt_hist[i-1];
    end
    raw_hist[0]  = x;
    filt_hist[0] = r.filtered;
    if (kept < FILTER_ORDER) kept++;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    filter_result_t want;
    int             i;
    if (!rst_ni) begin
      for (i = 0; i < MAX_TAPS; i++) begin
        fwd_coef[i] = iirdf1_pkg::COEF_ZERO;
        fbk_coef[i] = iirdf1_pkg::COEF_ZERO;
      end
      fwd_coef[0] = iirdf1_pkg::COEF_ONE;
      for (i = 0; i < FILTER_ORDER; i++) begin
        raw_hist[i]  = '0;
        filt_hist[i] = '0;
      end
      kept  = 0;
      fails = 0;
      seen  = 0;
      clips = 0;
      expected_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      results_o    <= 0;
      clip_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          iirdf1_pkg::CFG_FWD0: fwd_coef[0] = cfg_data_i;
          iirdf1_pkg::CFG_FWD1: fwd_coef[1] = cfg_data_i;
          iirdf1_pkg::CFG_FWD2: fwd_coef[2] = cfg_data_i;
          iirdf1_pkg::CFG_FBK1: fbk_coef[1] = cfg_data_i;
          iirdf1_pkg::CFG_FBK2: fbk_coef[2] = cfg_data_i;
          default: ;  // no register behind this index
        endcase
      end
      // a result can never belong to a sample taken at the same edge
      if (out_valid_i && out_ready_i) begin
        seen++;
        if (clipped_i === 1'b1) clips++;
        if (expected_results.size() == 0) begin
          $error("output transaction with no sample pending: filtered_out %0d clipped %0b",
                 filtered_out_i, clipped_i);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (filtered_out_i !== want.filtered) begin
            $error("filtered_out mismatch: expected %0d, got %0d", want.filtered, filtered_out_i);
            fails++;
          end
          if (clipped_i !== want.clipped) begin
            $error("clipped mismatch: expected %0b, got %0b", want.clipped, clipped_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(filter_sample(sample_in_i, restart_i));
      end
      fail_count_o <= fails;
      pending_o    <= expected_results.size();
      results_o    <= seen;
      clip_count_o <= clips;
    end
  end

endmodule

/* tb/tb_iir_direct_form_one_filter.sv */
// stimulus, handshake timing and verdict for the direct form I filter testbench
`timescale 1ns / 1ps
module tb_iir_direct_form_one_filter;
  import iirdf1_pkg::*;

  localparam int unsigned FILTER_ORDER = 2;
  localparam int PHASES          = 12;
  localparam int SAMPLES_PER_SET = 148;
  localparam int LONG_HOLD       = 300;
  localparam int SETTLE_CYCLES   = 2 * FILTER_ORDER + 8;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int COEF_MAX   = (1 << (COEF_W - 1)) - 1;
  localparam int COEF_MIN   = -(1 << (COEF_W - 1));
  localparam int SAMPLE_MAX = (1 << (SAMPLE_W - 1)) - 1;
  localparam int SAMPLE_MIN = -(1 << (SAMPLE_W - 1));

  typedef enum int {
    SET_LOWPASS,
    SET_HIGHPASS,
    SET_SMALL,
    SET_WIDE,
    SET_ALL_MAX,
    SET_ALL_MIN,
    SET_COUNT
  } coef_set_e;

  logic                         clk_i;
  logic                         rst_ni       = 1'b0;
  logic                         cfg_valid    = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index    = '0;
  logic [COEF_W-1:0]            cfg_data     = '0;
  logic                         in_valid     = 1'b0;
  logic                         in_ready;
  logic signed [SAMPLE_W-1:0]   sample_in    = '0;
  logic                         restart      = 1'b0;
  logic                         out_valid;
  logic                         out_ready    = 1'b0;
  logic signed [SAMPLE_W-1:0]   filtered_out;
  logic                         clipped;

  int fail_count;
  int pending;
  int results;
  int clip_count;
  int hold_req      = 0;
  bit gaps_on       = 1'b1;
  int restart_odds  = 40;
  int samples_sent  = 0;
  int restarts_sent = 0;
  int coef_writes   = 0;
  int quiet_cycles  = 0;

  iir_direct_form_one_filter #(
    .FILTER_ORDER (FILTER_ORDER)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .sample_in_i    (sample_in),
    .restart_i      (restart),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .filtered_out_o (filtered_out),
    .clipped_o      (clipped)
  );

  iirdf1_checker #(
    .FILTER_ORDER (FILTER_ORDER)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .sample_in_i    (sample_in),
    .restart_i      (restart),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .filtered_out_i (filtered_out),
    .clipped_i      (clipped),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results),
    .clip_count_o   (clip_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 65535) + SAMPLE_MIN;
    if (r == 6) begin
      case ($urandom_range(0, 3))
        0:       return SAMPLE_MAX;
        1:       return SAMPLE_MIN;
        2:       return -1;
        default: return 0;
      endcase
    end
    return $urandom_range(0, 512) - 256;
  endfunction

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[COEF_W-1:0];
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    coef_writes++;
  endtask

  task automatic load_coefs(input int b0, input int b1, input int b2, input int a1,
                            input int a2);
    write_coef(CFG_FWD0, b0);
    write_coef(CFG_FWD1, b1);
    write_coef(CFG_FWD2, b2);
    write_coef(CFG_FBK1, a1);
    write_coef(CFG_FBK2, a2);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // writes to the indexes above the last register must change nothing
  task automatic write_unused_indexes();
    int k;
    for (k = 1; k < (1 << CFG_IDX_W) - int'(CFG_FBK2); k++) begin
      write_coef(CFG_FBK2 + CFG_IDX_W'(k), $urandom_range(0, (1 << COEF_W) - 1));
    end
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(input int x, input bit rs);
    int gap;
    in_valid  <= 1'b1;
    sample_in <= x[SAMPLE_W-1:0];
    restart   <= rs;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    samples_sent++;
    if (rs) restarts_sent++;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_coef_set(input coef_set_e kind);
    case (kind)
      SET_LOWPASS:  load_coefs(1034, 2068, 1034, -19661, 7373);
      SET_HIGHPASS: load_coefs(12288, -24576, 12288, -19661, 7373);
      SET_SMALL:    load_coefs($urandom_range(0, 8192) - 4096, $urandom_range(0, 8192) - 4096,
                               $urandom_range(0, 8192) - 4096, $urandom_range(0, 8192) - 4096,
                               $urandom_range(0, 8192) - 4096);
      SET_WIDE:     load_coefs($urandom_range(0, (1 << COEF_W) - 1) + COEF_MIN,
                               $urandom_range(0, (1 << COEF_W) - 1) + COEF_MIN,
                               $urandom_range(0, (1 << COEF_W) - 1) + COEF_MIN,
                               $urandom_range(0, (1 << COEF_W) - 1) + COEF_MIN,
                               $urandom_range(0, (1 << COEF_W) - 1) + COEF_MIN);
      SET_ALL_MAX:  load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      default:      load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    endcase
  endtask

  initial begin : receiver
    int stall_left;
    int hold_seen;
    int seg_left;
    int r;
    bit steady;
    stall_left = 0;
    hold_seen  = 0;
    seg_left   = 0;
    steady     = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen  = hold_req;
        stall_left = LONG_HOLD;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 200);
        steady   = ($urandom_range(0, 3) == 0);
      end
      seg_left--;
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ready <= 1'b1;
        end else begin
          out_ready  <= 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (cfg_valid && cfg_ready) || (in_valid && in_ready)
        || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("no transaction for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending);
        $display("[iir_direct_form_one_filter] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int p;
    int k;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset coefficients pass the sample through
    send_sample(0, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(1, 1'b0);
    drain_results();

    // largest gains push the output into both rails
    load_coefs(COEF_MAX, 0, 0, 0, 0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(1, 1'b0);
    drain_results();
    load_coefs(COEF_MIN, 0, 0, 0, 0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(0, 1'b0);
    drain_results();

    // half-lsb ties round up, negative ties toward zero
    load_coefs(1, 0, 0, 0, 0);
    send_sample(8192, 1'b0);
    send_sample(-8192, 1'b0);
    send_sample(-8193, 1'b0);
    send_sample(24576, 1'b0);
    drain_results();

    // start-up with partial taps, back to back restarts
    load_coefs(16384, 8192, -4096, 4096, -2048);
    send_sample(12000, 1'b1);
    send_sample(-7000, 1'b0);
    send_sample(3000, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(500, 1'b1);
    send_sample(-500, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
    drain_results();

    write_unused_indexes();
    send_sample(1000, 1'b1);
    send_sample(2000, 1'b0);
    send_sample(-3000, 1'b0);

    for (p = 0; p < PHASES; p++) begin
      drain_results();
      load_coef_set(coef_set_e'(p % SET_COUNT));
      if ($urandom_range(0, 2) == 0) write_unused_indexes();
      gaps_on      = (p % 4 != 1) && (p != 2);
      restart_odds = (p % 3 == 0) ? 4 : 40;
      // sender keeps offering while the output is held off
      if (p == 2) hold_req++;
      for (k = 0; k < SAMPLES_PER_SET; k++) begin
        send_sample(pick_sample(), $urandom_range(0, restart_odds - 1) == 0);
      end
    end
    drain_results();

    $display("run: %0d samples (%0d with restart), %0d coefficient writes over %0d phases",
             samples_sent, restarts_sent, coef_writes, PHASES);
    $display("run: %0d results checked, %0d of them saturated", results, clip_count);
    if (pending != 0) begin
      $error("%0d expected results never arrived", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("[iir_direct_form_one_filter] OK");
    end else begin
      $display("[iir_direct_form_one_filter] ERROR");
    end
    $finish;
  end

endmodule
